// ===== src/rumble_effect_mixer_top_defines.svh =====
`ifndef RUMBLE_EFFECT_MIXER_TOP_DEFINES_SVH
`define RUMBLE_EFFECT_MIXER_TOP_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset
`define REM_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on the block's own clock and reset
`define REM_ASSERT(label, prop, msg) `REM_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// ===== src/rem_pkg.sv =====
`default_nettype none

package rem_pkg;

  localparam int TIME_W     = 32;
  localparam int LEVEL_IN_W = 16;

  // Command codes
  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_ADD        = 3'd1,
    CMD_FLUSH      = 3'd2,
    CMD_ACTIVATE   = 3'd3,
    CMD_DEACTIVATE = 3'd4
  } rem_cmd_e;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_TICK  = 5'b00100,
    S_ADD   = 5'b01000,
    S_RESP  = 5'b10000
  } rem_state_e;

  typedef struct packed {
    rem_cmd_e                cmd;
    logic [TIME_W-1:0]       now_ms;
    logic                    band;
    logic [LEVEL_IN_W-1:0]   level;
    logic [TIME_W-1:0]       duration_ms;
    logic [TIME_W-1:0]       start_ms;
  } rem_req_t;

  typedef struct packed {
    logic [LEVEL_IN_W-1:0] lo_level;
    logic [LEVEL_IN_W-1:0] hi_level;
    logic                  drive_valid;
    logic                  motors_on;
    logic                  add_dropped;
  } rem_rsp_t;

endpackage

`default_nettype wire

// ===== src/rem_ram.sv =====
`default_nettype none

module rem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/rem_walker.sv =====
`default_nettype none
`include "rumble_effect_mixer_top_defines.svh"

module rem_walker import rem_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int LEVEL_BITS  = 16,
  localparam int IdxW   = $clog2(TABLE_DEPTH),
  localparam int EntryW = 3 + LEVEL_BITS + 2 * TIME_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire rem_req_t          req_i,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output rem_rsp_t               rsp_o,
  output logic                   ram_we_o,
  output logic [IdxW-1:0]        ram_waddr_o,
  output logic [EntryW-1:0]      ram_wdata_o,
  output logic                   ram_re_o,
  output logic [IdxW-1:0]        ram_raddr_o,
  input  wire logic [EntryW-1:0] ram_rdata_i
);

  localparam int CntW = IdxW + 1;

  typedef struct packed {
    logic                  used;
    logic                  band;
    logic                  unstamped;
    logic [LEVEL_BITS-1:0] level;
    logic [TIME_W-1:0]     start;
    logic [TIME_W-1:0]     dur;
  } entry_t;

  rem_state_e            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pv_q, pv_d;
  logic [IdxW-1:0]       pidx_q, pidx_d;
  logic [LEVEL_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic                  active_q, active_d;
  logic                  clr_rsp_q, clr_rsp_d;
  rem_req_t              req_q, req_d;
  rem_rsp_t              res_q, res_d;

  entry_t                rd_ent, wr_ent, new_ent;
  logic                  cnt_end;
  logic [TIME_W-1:0]     stamp;
  logic [TIME_W:0]       exp_sum;
  logic                  expire;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = res_q;

  // Slot arithmetic: stamping, 33-bit expiry test, fresh entry for add
  always_comb begin
    rd_ent  = entry_t'(ram_rdata_i);
    stamp   = rd_ent.unstamped ? req_q.now_ms : rd_ent.start;
    exp_sum = {1'b0, stamp} + {1'b0, rd_ent.dur};
    expire  = ({1'b0, req_q.now_ms} >= exp_sum);

    new_ent.used      = 1'b1;
    new_ent.band      = req_q.band;
    new_ent.unstamped = (req_q.start_ms == '0);
    new_ent.level     = LEVEL_BITS'(req_q.level);
    new_ent.start     = req_q.start_ms;
    new_ent.dur       = req_q.duration_ms;
  end

  // Sequencer: clear sweep, tick walk, add search
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pv_d      = 1'b0;
    pidx_d    = pidx_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    active_d  = active_q;
    clr_rsp_d = clr_rsp_q;
    req_d     = req_q;
    res_d     = res_q;
    wr_ent    = rd_ent;
    cnt_end   = (cnt_q == CntW'(TABLE_DEPTH));

    ram_we_o    = 1'b0;
    ram_waddr_o = pidx_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = cnt_q[IdxW-1:0];

    case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q[IdxW-1:0];
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CntW'(TABLE_DEPTH - 1)) begin
          state_d = clr_rsp_q ? S_RESP : S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
          cnt_d = '0;
          res_d = '0;
          case (req_i.cmd)
            CMD_TICK: begin
              lo_d    = '0;
              hi_d    = '0;
              state_d = S_TICK;
            end
            CMD_ADD: begin
              state_d = S_ADD;
            end
            CMD_FLUSH: begin
              clr_rsp_d = 1'b1;
              state_d   = S_CLEAR;
            end
            CMD_ACTIVATE: begin
              active_d = 1'b1;
              state_d  = S_RESP;
            end
            CMD_DEACTIVATE: begin
              active_d          = 1'b0;
              clr_rsp_d         = 1'b1;
              res_d.drive_valid = 1'b1;
              state_d           = S_CLEAR;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_TICK: begin
        // read slot i while slot i-1 is written back
        if (!cnt_end) begin
          ram_re_o = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          pv_d     = 1'b1;
          pidx_d   = cnt_q[IdxW-1:0];
        end
        if (pv_q && rd_ent.used) begin
          wr_ent.start     = stamp;
          wr_ent.unstamped = 1'b0;
          if (active_q) begin
            if (!rd_ent.band && (rd_ent.level > lo_q)) begin
              lo_d = rd_ent.level;
            end
            if (rd_ent.band && (rd_ent.level > hi_q)) begin
              hi_d = rd_ent.level;
            end
            if (expire) begin
              wr_ent.used = 1'b0;
            end
          end
          ram_we_o    = 1'b1;
          ram_wdata_o = wr_ent;
        end
        if (cnt_end) begin
          res_d.lo_level    = LEVEL_IN_W'(lo_d);
          res_d.hi_level    = LEVEL_IN_W'(hi_d);
          res_d.drive_valid = 1'b1;
          res_d.motors_on   = (LEVEL_IN_W'(lo_d) != '0) || (LEVEL_IN_W'(hi_d) != '0);
          state_d           = S_RESP;
        end
      end

      S_ADD: begin
        if (!cnt_end) begin
          ram_re_o = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          pv_d     = 1'b1;
          pidx_d   = cnt_q[IdxW-1:0];
        end
        if (pv_q && !rd_ent.used) begin
          // first free slot
          ram_we_o    = 1'b1;
          ram_wdata_o = new_ent;
          pv_d        = 1'b0;
          state_d     = S_RESP;
        end else if (cnt_end) begin
          res_d.add_dropped = 1'b1;
          state_d           = S_RESP;
        end
      end

      S_RESP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      active_q  <= 1'b1;
      clr_rsp_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pv_q      <= pv_d;
      active_q  <= active_d;
      clr_rsp_q <= clr_rsp_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    req_q  <= req_d;
    res_q  <= res_d;
  end

  `REM_ASSERT(a_cnt_range, cnt_q <= CntW'(TABLE_DEPTH), "slot counter past table end")
  `REM_ASSERT(a_no_rw_same_slot, ram_we_o && ram_re_o |-> ram_waddr_o != ram_raddr_o, "rw on one slot")
  `REM_ASSERT(a_pv_in_walk, pv_q |-> (state_q == S_TICK || state_q == S_ADD), "stray slot data")
  `REM_ASSERT(a_accept_busy, req_valid_i && req_ready_o |=> state_q != S_IDLE, "idle after accept")

endmodule

`default_nettype wire

// ===== src/rem_out_reg.sv =====
`default_nettype none

module rem_out_reg import rem_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire rem_rsp_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output rem_rsp_t      out_data_o
);

  logic     valid_q, valid_d;
  rem_rsp_t data_q;

  // Refill whenever empty or draining this cycle
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/rumble_effect_mixer_top.sv =====
`default_nettype none

// Rumble effect mixer: every request gives exactly one response. Effects live
// in a TABLE_DEPTH-entry single-read-port RAM and are visited one slot per
// cycle. A tick walks the whole table before its response enters the output
// register; an add stops at the first free slot.
// Reset, flush and deactivate clear the table with a write sweep; activate
// and unknown commands go straight to the response. After the reset pin is
// released the same sweep runs with req_ready_o low. A finished response
// waits in the output register while the next request is taken.
module rumble_effect_mixer_top import rem_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int LEVEL_BITS  = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire rem_req_t req_i,
  output logic          rsp_valid_o,
  input  wire logic     rsp_ready_i,
  output rem_rsp_t      rsp_o
);

  localparam int IdxW   = $clog2(TABLE_DEPTH);
  localparam int EntryW = 3 + LEVEL_BITS + 2 * TIME_W;

  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic              wk_rsp_valid, wk_rsp_ready;
  rem_rsp_t          wk_rsp;

  // Slot table
  rem_ram #(
    .WIDTH (EntryW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Command sequencer and slot read-modify-write
  rem_walker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (wk_rsp_valid),
    .rsp_ready_i (wk_rsp_ready),
    .rsp_o       (wk_rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Response register
  rem_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wk_rsp_valid),
    .in_ready_o  (wk_rsp_ready),
    .in_data_i   (wk_rsp),
    .out_valid_o (rsp_valid_o),
    .out_ready_i (rsp_ready_i),
    .out_data_o  (rsp_o)
  );

endmodule

`default_nettype wire
